// ----- rtl/med_context_bias_predictor_defines.svh -----
// Assertion macros for the context-modeled median predictor.
`ifndef MED_CONTEXT_BIAS_PREDICTOR_DEFINES_SVH
`define MED_CONTEXT_BIAS_PREDICTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define MCB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mcb assertion failed");
`define MCB_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("mcb forbidden condition");
`else
`define MCB_ASSERT(lbl, clk, rstn, prop)
`define MCB_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- rtl/mcb_pkg.sv -----
// Types and constants of the context-modeled median predictor.
package mcb_pkg;

  localparam int unsigned CONTEXT_COUNT = 365;
  localparam int unsigned KW            = 9;
  localparam int unsigned CFG_DW        = 13;
  localparam int unsigned T1            = 3;
  localparam int unsigned T2            = 7;
  localparam int unsigned T3            = 21;

  localparam logic REG_DECODE_MODE = 1'b0;
  localparam logic REG_IMAGE_WIDTH = 1'b1;

  typedef struct packed {
    logic              first_of_image;
    logic [7:0]        pixel_in;
    logic signed [7:0] residual_in;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] residual_out;
    logic [7:0]        pixel_out;
    logic [KW-1:0]     context_index;
    logic              context_negative;
  } out_item_t;

endpackage

// ----- rtl/mcb_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transfer.
interface mcb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/med_context_bias_predictor.sv -----
// Median edge predictor with per-context bias correction, 8-bit pixels in raster order.
// A new pixel is taken only once the last one has left stage B; results pass stage B,
// stage C and the output register. The left-pixel and context feedback set this: the
// context index needs the previous pixel, and the context entry is read from a
// registered memory before the bias can be applied. The previous row sits in a
// dual-read memory of MAX_WIDTH bytes, the context store (N, B, C) in a memory of 365
// entries. After reset and before a first_of_image item is taken, a clearing pass of all
// entries initializes the store; it takes no input, but configuration writes are taken.
`include "med_context_bias_predictor_defines.svh"

module med_context_bias_predictor #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned RESET_COUNT = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [mcb_pkg::CFG_DW-1:0] cfg_data_i,
  mcb_stream_if.sink                in_i,
  mcb_stream_if.source              out_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned XW = AW + 1;
  localparam int unsigned LW = (XW > mcb_pkg::CFG_DW) ? XW : mcb_pkg::CFG_DW;
  localparam int unsigned NW = $clog2(RESET_COUNT);
  localparam int unsigned BW = NW + 1;
  localparam int unsigned EW = NW + BW + 8;
  localparam int unsigned CW = NW + 10;
  localparam int unsigned KW = mcb_pkg::KW;

  // configuration
  logic                       decode_q;
  logic [mcb_pkg::CFG_DW-1:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q <= 1'b0;
      width_q  <= mcb_pkg::CFG_DW'(512);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcb_pkg::REG_DECODE_MODE: decode_q <= cfg_data_i[0];
        mcb_pkg::REG_IMAGE_WIDTH: width_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  logic          v1_q, v2_q, ov_q;
  logic          clearing_q, fresh_q;
  logic [KW-1:0] clr_cnt_q;
  logic          c_go, accept, clr_start, clr_end;

  assign c_go   = v2_q && (!ov_q || out_o.ready);
  assign in_i.ready = !clearing_q && !v1_q && (!v2_q || c_go) &&
                      (!in_i.data.first_of_image || fresh_q);
  assign accept = in_i.valid && in_i.ready;
  assign clr_start = in_i.valid && in_i.data.first_of_image && !fresh_q &&
                     !clearing_q && !v1_q && !v2_q;
  assign clr_end = clearing_q && (clr_cnt_q == KW'(mcb_pkg::CONTEXT_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      ov_q       <= 1'b0;
      clearing_q <= 1'b1;
      fresh_q    <= 1'b0;
      clr_cnt_q  <= '0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q || (v2_q && !c_go);
      if (c_go) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (clr_start) begin
        clearing_q <= 1'b1;
        clr_cnt_q  <= '0;
      end else if (clr_end) begin
        clearing_q <= 1'b0;
        fresh_q    <= 1'b1;
      end else if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + KW'(1);
      end
      if (accept) begin
        fresh_q <= 1'b0;
      end
    end
  end

  // row position
  logic [AW-1:0] col_q;
  logic          frow_q;
  logic [AW-1:0] x_a;
  logic [XW-1:0] x1_a;
  logic          fr_a, last_a;
  logic [LW-1:0] w_eff;
  logic [AW-1:0] addr_b, addr_d;

  always_comb begin
    if (width_q == '0) begin
      w_eff = LW'(1);
    end else if (LW'(width_q) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(width_q);
    end
    x_a    = in_i.data.first_of_image ? '0 : col_q;
    fr_a   = in_i.data.first_of_image | frow_q;
    x1_a   = XW'(x_a) + XW'(1);
    last_a = LW'(x1_a) >= w_eff;
    addr_b = x_a;
    addr_d = last_a ? x_a : x1_a[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      frow_q <= 1'b1;
    end else if (accept) begin
      col_q  <= last_a ? '0 : x1_a[AW-1:0];
      frow_q <= last_a ? 1'b0 : fr_a;
    end
  end

  // stage B registers
  logic [AW-1:0]     xb_q;
  logic              x0b_q, lastb_q, frb_q;
  logic [7:0]        pixb_q;
  logic signed [7:0] resb_q;
  logic              decb_q;

  // stage C registers
  logic [AW-1:0]     xc_q;
  logic [7:0]        pixc_q;
  logic signed [7:0] resc_q;
  logic              decc_q, negc_q;
  logic [7:0]        medc_q;
  logic [KW-1:0]     kc_q;

  // row memory with forwarding of the same-edge write
  logic [7:0] row_mem [MAX_WIDTH];
  logic [7:0] rd_b_q, rd_d_q, fwd_pix_q;
  logic       fwd_b_q, fwd_d_q;
  logic [7:0] pix_c;

  always_ff @(posedge clk_i) begin
    if (c_go) begin
      row_mem[xc_q] <= pix_c;
    end
    if (accept) begin
      rd_b_q    <= row_mem[addr_b];
      rd_d_q    <= row_mem[addr_d];
      fwd_b_q   <= c_go && (xc_q == addr_b);
      fwd_d_q   <= c_go && (xc_q == addr_d);
      fwd_pix_q <= pix_c;
      xb_q      <= x_a;
      x0b_q     <= (x_a == '0);
      lastb_q   <= last_a;
      frb_q     <= fr_a;
      pixb_q    <= in_i.data.pixel_in;
      resb_q    <= in_i.data.residual_in;
      decb_q    <= decode_q;
    end
  end

  // stage B: neighbors, prediction and context
  logic [7:0] left_q, prev_q;
  logic [7:0] a_s, b_s, c_s, d_s, mx, mn, med_s;
  logic signed [3:0] q1, q2, q3, f1, f2, f3;
  logic       neg_s;
  logic [9:0] idx;
  logic [KW-1:0] k_s;

  function automatic logic signed [3:0] quant(input logic signed [8:0] g);
    logic signed [3:0] q;
    if (g <= -9'sd21) q = -4'sd4;
    else if (g <= -9'sd7) q = -4'sd3;
    else if (g <= -9'sd3) q = -4'sd2;
    else if (g < 9'sd0) q = -4'sd1;
    else if (g == 9'sd0) q = 4'sd0;
    else if (g < 9'sd3) q = 4'sd1;
    else if (g < 9'sd7) q = 4'sd2;
    else if (g < 9'sd21) q = 4'sd3;
    else q = 4'sd4;
    return q;
  endfunction

  always_comb begin
    b_s = frb_q ? 8'd0 : (fwd_b_q ? fwd_pix_q : rd_b_q);
    if (frb_q) begin
      d_s = 8'd0;
    end else if (lastb_q) begin
      d_s = b_s;
    end else begin
      d_s = fwd_d_q ? fwd_pix_q : rd_d_q;
    end
    c_s = x0b_q ? b_s : (frb_q ? 8'd0 : prev_q);
    a_s = x0b_q ? b_s : left_q;
    mx  = (a_s > b_s) ? a_s : b_s;
    mn  = (a_s > b_s) ? b_s : a_s;
    if (c_s >= mx) begin
      med_s = mn;
    end else if (c_s <= mn) begin
      med_s = mx;
    end else begin
      med_s = 8'(9'(a_s) + 9'(b_s) - 9'(c_s));
    end
    q1 = quant($signed({1'b0, d_s}) - $signed({1'b0, b_s}));
    q2 = quant($signed({1'b0, b_s}) - $signed({1'b0, c_s}));
    q3 = quant($signed({1'b0, c_s}) - $signed({1'b0, a_s}));
    neg_s = (q1 < 0) || (q1 == 0 && q2 < 0) || (q1 == 0 && q2 == 0 && q3 < 0);
    f1 = neg_s ? -q1 : q1;
    f2 = neg_s ? -q2 : q2;
    f3 = neg_s ? -q3 : q3;
    idx = 10'(unsigned'(4'(f1 + 4'sd4))) * 10'd81 +
          10'(unsigned'(4'(f2 + 4'sd4))) * 10'd9 +
          10'(unsigned'(4'(f3 + 4'sd4)));
    if ((idx >> 1) >= 10'd364) begin
      k_s = KW'(364);
    end else begin
      k_s = KW'((idx >> 1) + 10'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      xc_q   <= xb_q;
      pixc_q <= pixb_q;
      resc_q <= resb_q;
      decc_q <= decb_q;
      negc_q <= neg_s;
      medc_q <= med_s;
      kc_q   <= k_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 8'd0;
      prev_q <= 8'd0;
    end else begin
      if (v1_q) begin
        prev_q <= b_s;
      end
      if (c_go) begin
        left_q <= pix_c;
      end
    end
  end

  // context memory: read in stage B, written back in stage C
  logic [EW-1:0] ctx_mem [mcb_pkg::CONTEXT_COUNT];
  logic [EW-1:0] ctx_rd_q, ctx_wr;
  logic [EW-1:0] ctx_init;

  assign ctx_init = {NW'(1), BW'(0), 8'd0};

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      ctx_mem[clr_cnt_q] <= ctx_init;
    end else if (c_go) begin
      ctx_mem[kc_q] <= ctx_wr;
    end
    if (v1_q) begin
      ctx_rd_q <= ctx_mem[k_s];
    end
  end

  // stage C: bias, residual, context update
  logic [NW-1:0]        n_old;
  logic signed [BW-1:0] b_old;
  logic signed [7:0]    c_old, e_c;
  logic signed [9:0]    p_s, c_w;
  logic [7:0]           pred;
  logic [7:0]           diff;
  logic signed [CW-1:0] n_w, b_w;

  always_comb begin
    n_old = ctx_rd_q[EW-1 -: NW];
    b_old = $signed(ctx_rd_q[BW+7 -: BW]);
    c_old = $signed(ctx_rd_q[7:0]);
    p_s = negc_q ? $signed({2'b00, medc_q}) - 10'(c_old)
                 : $signed({2'b00, medc_q}) + 10'(c_old);
    if (p_s < 0) begin
      pred = 8'd0;
    end else if (p_s > 10'sd255) begin
      pred = 8'd255;
    end else begin
      pred = p_s[7:0];
    end
    if (decc_q) begin
      e_c   = resc_q;
      diff  = negc_q ? 8'(-resc_q) : resc_q;
      pix_c = pred + diff;
    end else begin
      pix_c = pixc_q;
      diff  = pixc_q - pred;
      e_c   = negc_q ? $signed(8'(-diff)) : $signed(diff);
    end
    n_w = $signed(CW'(n_old)) + CW'(1);
    b_w = CW'(b_old) + CW'(e_c);
    c_w = 10'(c_old);
    if (b_w <= -n_w) begin
      c_w = c_w - 10'sd1;
      b_w = b_w + n_w;
      if (b_w <= -n_w) begin
        b_w = -n_w + CW'(1);
      end
    end else if (b_w > 0) begin
      c_w = c_w + 10'sd1;
      b_w = b_w - n_w;
      if (b_w > 0) begin
        b_w = '0;
      end
    end
    if (n_w >= $signed(CW'(RESET_COUNT))) begin
      n_w = n_w >>> 1;
      b_w = b_w >>> 1;
    end
    if (c_w < -10'sd128) begin
      c_w = -10'sd128;
    end else if (c_w > 10'sd127) begin
      c_w = 10'sd127;
    end
    ctx_wr = {n_w[NW-1:0], b_w[BW-1:0], c_w[7:0]};
  end

  // output register
  mcb_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (c_go) begin
      out_q.residual_out     <= e_c;
      out_q.pixel_out        <= pix_c;
      out_q.context_index    <= kc_q;
      out_q.context_negative <= negc_q;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  `MCB_NEVER(a_stage_overlap, clk_i, rst_ni, v1_q && v2_q)
  `MCB_NEVER(a_accept_in_clear, clk_i, rst_ni, clearing_q && accept)
  `MCB_ASSERT(a_accept_advances, clk_i, rst_ni, accept |=> v1_q)
  `MCB_ASSERT(a_finish_shows, clk_i, rst_ni, c_go |=> ov_q)
  `MCB_NEVER(a_clear_with_work, clk_i, rst_ni, clearing_q && (v1_q || v2_q))

endmodule
